@@ rtl/core/rlof_pkg.sv @@
// shared types, constants and gamma table for the rgbw led oscillator fader
package rlof_pkg;

    localparam int LEVEL_W     = 8;
    localparam int THRESH_W    = 11;
    localparam int GAMMA_W     = 10;
    localparam int CHANNELS    = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OSC_ENABLE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OSC_SPEED      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OSC_BRIGHTNESS = 2'd2;

    // item kinds
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_WHITE = 2'd3;

    // oscillation constants
    localparam logic [6:0] RED_PHASES   = 7'b1001101;
    localparam logic [6:0] GREEN_PHASES = 7'b0100111;
    localparam logic [6:0] BLUE_PHASES  = 7'b0011011;
    localparam logic [2:0] LAST_PHASE   = 3'd6;
    localparam logic [7:0] HALF_PEAK    = 8'd127;
    localparam logic [7:0] WHITE_LOW    = 8'd64;
    localparam logic [7:0] WHITE_HIGH   = 8'd196;
    localparam logic [THRESH_W-1:0] THRESH_FULL = 11'd1024;

    // reset values of the configuration registers
    localparam logic       OSC_ENABLE_RST     = 1'b1;
    localparam logic [7:0] OSC_SPEED_RST      = 8'd127;
    localparam logic [7:0] OSC_BRIGHTNESS_RST = 8'd127;

    typedef logic [CHANNELS-1:0][LEVEL_W-1:0] level_vec_t;

    typedef struct packed {
        logic                    we;
        logic [CFG_INDEX_W-1:0]  index;
        logic [CFG_DATA_W-1:0]   data;
    } cfg_write_t;

    // target update produced by one peak step
    typedef struct packed {
        logic               load;
        logic               red_hit;
        logic               green_hit;
        logic               blue_hit;
        logic [LEVEL_W-1:0] colour;
        logic [LEVEL_W-1:0] white;
    } osc_update_t;

    localparam logic [GAMMA_W-1:0] GAMMA_LUT [256] = '{
        10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1, 10'd1, 10'd1,
        10'd1, 10'd1, 10'd2, 10'd2, 10'd2, 10'd3, 10'd3, 10'd3, 10'd4, 10'd4, 10'd5, 10'd5,
        10'd6, 10'd6, 10'd7, 10'd7, 10'd8, 10'd9, 10'd9, 10'd10, 10'd11, 10'd11, 10'd12,
        10'd13, 10'd14, 10'd15, 10'd16, 10'd16, 10'd17, 10'd18, 10'd19, 10'd20, 10'd21,
        10'd23, 10'd24, 10'd25, 10'd26, 10'd27, 10'd28, 10'd30, 10'd31, 10'd32, 10'd34,
        10'd35, 10'd36, 10'd38, 10'd39, 10'd41, 10'd42, 10'd44, 10'd46, 10'd47, 10'd49,
        10'd51, 10'd52, 10'd54, 10'd56, 10'd58, 10'd60, 10'd61, 10'd63, 10'd65, 10'd67,
        10'd69, 10'd71, 10'd73, 10'd76, 10'd78, 10'd80, 10'd82, 10'd84, 10'd87, 10'd89,
        10'd91, 10'd94, 10'd96, 10'd98, 10'd101, 10'd103, 10'd106, 10'd109, 10'd111,
        10'd114, 10'd117, 10'd119, 10'd122, 10'd125, 10'd128, 10'd130, 10'd133, 10'd136,
        10'd139, 10'd142, 10'd145, 10'd148, 10'd151, 10'd155, 10'd158, 10'd161, 10'd164,
        10'd167, 10'd171, 10'd174, 10'd177, 10'd181, 10'd184, 10'd188, 10'd191, 10'd195,
        10'd198, 10'd202, 10'd206, 10'd209, 10'd213, 10'd217, 10'd221, 10'd225, 10'd228,
        10'd232, 10'd236, 10'd240, 10'd244, 10'd248, 10'd252, 10'd257, 10'd261, 10'd265,
        10'd269, 10'd274, 10'd278, 10'd282, 10'd287, 10'd291, 10'd295, 10'd300, 10'd304,
        10'd309, 10'd314, 10'd318, 10'd323, 10'd328, 10'd333, 10'd337, 10'd342, 10'd347,
        10'd352, 10'd357, 10'd362, 10'd367, 10'd372, 10'd377, 10'd382, 10'd387, 10'd393,
        10'd398, 10'd403, 10'd408, 10'd414, 10'd419, 10'd425, 10'd430, 10'd436, 10'd441,
        10'd447, 10'd452, 10'd458, 10'd464, 10'd470, 10'd475, 10'd481, 10'd487, 10'd493,
        10'd499, 10'd505, 10'd511, 10'd517, 10'd523, 10'd529, 10'd535, 10'd542, 10'd548,
        10'd554, 10'd561, 10'd567, 10'd573, 10'd580, 10'd586, 10'd593, 10'd599, 10'd606,
        10'd613, 10'd619, 10'd626, 10'd633, 10'd640, 10'd647, 10'd653, 10'd660, 10'd667,
        10'd674, 10'd681, 10'd689, 10'd696, 10'd703, 10'd710, 10'd717, 10'd725, 10'd732,
        10'd739, 10'd747, 10'd754, 10'd762, 10'd769, 10'd777, 10'd784, 10'd792, 10'd800,
        10'd807, 10'd815, 10'd823, 10'd831, 10'd839, 10'd847, 10'd855, 10'd863, 10'd871,
        10'd879, 10'd887, 10'd895, 10'd903, 10'd912, 10'd920, 10'd928, 10'd937, 10'd945,
        10'd954, 10'd962, 10'd971, 10'd979, 10'd988, 10'd997, 10'd1005, 10'd1014, 10'd1023
    };

    // inverted off threshold of one level
    function automatic logic [THRESH_W-1:0] gamma_threshold(input logic [LEVEL_W-1:0] level);
        return THRESH_FULL - {1'b0, GAMMA_LUT[level]};
    endfunction

endpackage

@@ rtl/core/rlof_osc.sv @@
// oscillator: config registers, speed divider, peak position, phase and triangle values
module rlof_osc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rlof_pkg::cfg_write_t cfg,
    input  logic                 tick,
    output rlof_pkg::osc_update_t upd
);

    logic       osc_enable_reg;
    logic [7:0] osc_speed_reg;
    logic [7:0] osc_brightness_reg;

    logic [8:0] tick_count_reg, tick_count_next;
    logic [7:0] peak_step_reg, peak_step_next;
    logic [2:0] phase_index_reg, phase_index_next;

    logic [8:0]  count_inc;
    logic [8:0]  count_limit;
    logic        step;
    logic [7:0]  peak_inc;
    logic [7:0]  colour_fac;
    logic [7:0]  white_fac;
    logic        white_band;
    logic [15:0] colour_prod;
    logic [15:0] white_prod;
    logic [2:0]  phase_inc;
    logic [2:0]  mask_pos;
    logic [6:0]  mask_bit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_enable_reg     <= rlof_pkg::OSC_ENABLE_RST;
            osc_speed_reg      <= rlof_pkg::OSC_SPEED_RST;
            osc_brightness_reg <= rlof_pkg::OSC_BRIGHTNESS_RST;
        end else if (cfg.we) begin
            case (cfg.index)
                rlof_pkg::CFG_OSC_ENABLE:     osc_enable_reg     <= cfg.data[0];
                rlof_pkg::CFG_OSC_SPEED:      osc_speed_reg      <= cfg.data;
                rlof_pkg::CFG_OSC_BRIGHTNESS: osc_brightness_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // speed divider: peak steps every 256 - speed ticks
    assign count_inc   = tick_count_reg + 9'd1;
    assign count_limit = 9'd256 - {1'b0, osc_speed_reg};
    assign step        = tick && osc_enable_reg && (count_inc >= count_limit);

    // triangle values of the next peak position
    assign peak_inc    = peak_step_reg + 8'd1;
    assign colour_fac  = (peak_inc <= rlof_pkg::HALF_PEAK) ? peak_inc : ~peak_inc;
    assign colour_prod = colour_fac * osc_brightness_reg;
    assign white_band  = (peak_inc >= rlof_pkg::WHITE_LOW) && (peak_inc < rlof_pkg::WHITE_HIGH);
    assign white_fac   = (peak_inc <= rlof_pkg::HALF_PEAK)
                       ? {1'b0, peak_inc[5:0], 1'b0}
                       : {7'(rlof_pkg::WHITE_HIGH - peak_inc), 1'b0};
    assign white_prod  = white_fac * osc_brightness_reg;

    // phase advances when the peak wraps to zero
    assign phase_inc = (phase_index_reg >= rlof_pkg::LAST_PHASE) ? 3'd0
                                                                 : phase_index_reg + 3'd1;

    always_comb begin
        tick_count_next  = tick_count_reg;
        peak_step_next   = peak_step_reg;
        phase_index_next = phase_index_reg;
        if (tick && osc_enable_reg) begin
            tick_count_next = step ? 9'd0 : count_inc;
        end
        if (step) begin
            peak_step_next = peak_inc;
            if (peak_inc == 8'd0) begin
                phase_index_next = phase_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= 9'd0;
            peak_step_reg   <= 8'd0;
            phase_index_reg <= 3'd0;
        end else begin
            tick_count_reg  <= tick_count_next;
            peak_step_reg   <= peak_step_next;
            phase_index_reg <= phase_index_next;
        end
    end

    // channel selection by phase mask
    assign mask_pos = rlof_pkg::LAST_PHASE - phase_index_next;
    assign mask_bit = 7'd1 << mask_pos;

    assign upd.load      = step;
    assign upd.red_hit   = |(rlof_pkg::RED_PHASES & mask_bit);
    assign upd.green_hit = |(rlof_pkg::GREEN_PHASES & mask_bit);
    assign upd.blue_hit  = |(rlof_pkg::BLUE_PHASES & mask_bit);
    assign upd.colour    = colour_prod[15:8];
    assign upd.white     = white_band ? white_prod[15:8] : 8'd0;

endmodule

@@ rtl/core/rlof_slew.sv @@
// target and current levels of the four channels, with one-step slewing
module rlof_slew (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  logic                   is_write,
    input  logic [1:0]             channel,
    input  logic [7:0]             value,
    input  rlof_pkg::osc_update_t  upd,
    output rlof_pkg::level_vec_t   level_next
);

    rlof_pkg::level_vec_t target_reg, target_next;
    rlof_pkg::level_vec_t current_reg, current_next;

    // target update from a write or a peak step
    always_comb begin
        target_next = target_reg;
        if (fire && is_write) begin
            target_next[channel] = value;
        end else if (fire && upd.load) begin
            if (upd.red_hit) begin
                target_next[rlof_pkg::CH_RED] = upd.colour;
            end
            if (upd.green_hit) begin
                target_next[rlof_pkg::CH_GREEN] = upd.colour;
            end
            if (upd.blue_hit) begin
                target_next[rlof_pkg::CH_BLUE] = upd.colour;
            end
            target_next[rlof_pkg::CH_WHITE] = upd.white;
        end
    end

    // each level moves one step toward its target on a tick
    always_comb begin
        current_next = current_reg;
        if (fire && !is_write) begin
            for (int k = 0; k < rlof_pkg::CHANNELS; k++) begin
                if (current_reg[k] > target_next[k]) begin
                    current_next[k] = current_reg[k] - 8'd1;
                end else if (current_reg[k] < target_next[k]) begin
                    current_next[k] = current_reg[k] + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            current_reg <= '0;
        end else begin
            target_reg  <= target_next;
            current_reg <= current_next;
        end
    end

    assign level_next = current_next;

endmodule

@@ rtl/core/rgbw_led_oscillator_fader_top.sv @@
// top level of the rgbw led oscillator fader: input register, update logic, result register
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | s_mode, s_channel, s_value
//  m_      | out       | m_valid/m_ready  | m_red/green/blue/white_threshold
//  cfg_    | in        | cfg_we           | cfg_index, cfg_wdata
//
// one transaction per cycle while m_ready is high; path: input register, result register
// state is updated as a transaction moves from the input register to the result register
// a stalled result holds the result register; the input register still takes one more
// transaction, so s_ready drops only when both stages are full
// synchronous active-low reset restores the configuration defaults and clears all levels
module rgbw_led_oscillator_fader_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [1:0]  s_channel,
    input  logic [7:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_red_threshold,
    output logic [10:0] m_green_threshold,
    output logic [10:0] m_blue_threshold,
    output logic [10:0] m_white_threshold,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [1:0] in_channel_reg;
    logic [7:0] in_value_reg;

    logic                 m_valid_reg;
    rlof_pkg::level_vec_t level_out_reg;

    logic                  out_adv;
    logic                  fire;
    logic                  is_write;
    rlof_pkg::cfg_write_t  cfg;
    rlof_pkg::osc_update_t upd;
    rlof_pkg::level_vec_t  level_next;

    // pipeline flow control
    assign out_adv  = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_adv;
    assign fire     = in_valid_reg && out_adv;
    assign is_write = (in_mode_reg == rlof_pkg::MODE_WRITE);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg    <= s_mode;
            in_channel_reg <= s_channel;
            in_value_reg   <= s_value;
        end
    end

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    rlof_osc u_osc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .tick    (fire && !is_write),
        .upd     (upd)
    );

    rlof_slew u_slew (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .is_write   (is_write),
        .channel    (in_channel_reg),
        .value      (in_value_reg),
        .upd        (upd),
        .level_next (level_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            level_out_reg <= level_next;
        end
    end

    // gamma lookup and inversion of the held levels
    assign m_valid           = m_valid_reg;
    assign m_red_threshold   = rlof_pkg::gamma_threshold(level_out_reg[rlof_pkg::CH_RED]);
    assign m_green_threshold = rlof_pkg::gamma_threshold(level_out_reg[rlof_pkg::CH_GREEN]);
    assign m_blue_threshold  = rlof_pkg::gamma_threshold(level_out_reg[rlof_pkg::CH_BLUE]);
    assign m_white_threshold = rlof_pkg::gamma_threshold(level_out_reg[rlof_pkg::CH_WHITE]);

`ifndef NO_ASSERTIONS
    // an empty result stage always leaves room for a new transaction
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("s_ready low with empty result register");

    // a transaction leaving the input stage shows up as a result next cycle
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("transaction lost between stages");

    // a stalled input stage keeps its transaction
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(in_mode_reg)
            && $stable(in_channel_reg) && $stable(in_value_reg))
        else $error("input register changed while stalled");

    // a held result keeps its levels until taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(level_out_reg))
        else $error("result levels changed while stalled");
`endif

endmodule
